@@ rtl/core/bale_pkg.sv @@
package bale_pkg;

    // Field widths of the request and response transactions.
    localparam int MODE_W = 3;
    localparam int POS_W  = 7;
    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;

    // Request kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } t_state;

    // Store update that every cell applies in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    // Request transaction payload.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] item_value;
    } t_req;

    // Response transaction payload.
    typedef struct packed {
        logic                    status;
        logic [IDX_W-1:0]        found_index;
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_W-1:0]        entry_count;
    } t_rsp;

    // Store update broadcast to the cell chain.
    typedef struct packed {
        t_cell_op           op;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   value;
    } t_cell_cmd;

    // Probe that walks the chain one cell per cycle for a search or a read.
    // For a search, data carries the key; for a read, it collects the entry.
    typedef struct packed {
        logic               active;
        logic               search;
        logic               hit;
        logic [IDX_W-1:0]   found_index;
        logic [VAL_W-1:0]   data;
    } t_probe;

endpackage

@@ rtl/core/bale_stream_if.sv @@
interface bale_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

@@ rtl/core/bale_cell.sv @@
module bale_cell #(
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bale_pkg::t_cell_cmd  i_cmd,
    input  logic                 i_left_valid,
    input  logic [31:0]          i_left_data,
    input  logic                 i_right_valid,
    input  logic [31:0]          i_right_data,
    output logic                 o_valid,
    output logic [31:0]          o_data,
    input  bale_pkg::t_probe     i_probe,
    output bale_pkg::t_probe     o_probe
);
    import bale_pkg::*;

    localparam logic [31:0] INDEX_U = 32'(INDEX);

    logic             r_valid;
    logic             n_valid;
    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;
    t_probe           r_probe;
    t_probe           n_probe;
    logic             w_at_pos;
    logic             w_above_pos;

    assign w_at_pos    = (INDEX_U == 32'(i_cmd.position));
    assign w_above_pos = (INDEX_U >  32'(i_cmd.position));

    // Entry update: load, shift from a neighbor, or hold.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_cmd.op)
            CELL_APPEND: begin
                // The first empty cell takes the new value.
                if (!r_valid && i_left_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_cmd.value;
                end
            end
            CELL_INSERT: begin
                if (w_above_pos) begin
                    n_valid = i_left_valid;
                    n_data  = i_left_data;
                end else if (w_at_pos) begin
                    n_valid = 1'b1;
                    n_data  = i_cmd.value;
                end
            end
            CELL_REMOVE: begin
                if (w_above_pos || w_at_pos) begin
                    n_valid = i_right_valid;
                    n_data  = i_right_data;
                end
            end
            default: begin
            end
        endcase
    end

    // Probe stage: a search records the first live match, a read grabs the entry.
    always_comb begin
        n_probe = i_probe;
        if (i_probe.active) begin
            if (i_probe.search) begin
                if (!i_probe.hit && r_valid && (r_data == i_probe.data)) begin
                    n_probe.hit         = 1'b1;
                    n_probe.found_index = IDX_W'(INDEX);
                end
            end else if (w_at_pos) begin
                n_probe.hit  = 1'b1;
                n_probe.data = r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_data  <= '0;
            r_probe <= '0;
        end else begin
            r_valid <= n_valid;
            r_data  <= n_data;
            r_probe <= n_probe;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_probe = r_probe;

endmodule

@@ rtl/core/bounded_array_list_engine_core.sv @@
// Ordered list of up to DEPTH signed 32-bit entries kept in a chain of
// register cells, one entry per cell. Each request transaction on i_req
// yields exactly one response transaction on o_rsp. Append, insert and remove
// update every cell in parallel; their response, like that of rejected and
// undefined requests, is registered at acceptance and ready the cycle after.
// Search and in-range reads send a probe down the cell chain, one cell per
// clock, and their response is registered once the probe leaves the last
// cell. One request is in flight at a time; a finished response waits in
// the output register, and the next request is taken only once that register
// is empty or its transaction is being taken in the same cycle. Reset
// clears all cells and the count at once, with no clearing pass. DEPTH may
// range from 2 to 4096; found_index and entry_count carry the low bits of
// the index and the count.
module bounded_array_list_engine_core #(
    parameter int DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bale_stream_if.sink   i_req,
    bale_stream_if.source o_rsp
);
    import bale_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    t_state           r_state;
    t_state           n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             r_out_valid;
    logic             n_out_valid;
    t_rsp             r_out;
    t_rsp             n_out;
    t_rsp             r_hold;
    t_rsp             n_hold;

    t_cell_cmd        w_cmd;
    t_probe           w_launch;
    t_rsp             w_res;
    t_rsp             w_done;
    logic             w_can_load;
    logic             w_accept;
    logic             w_full;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;

    logic             w_valid [DEPTH];
    logic [VAL_W-1:0] w_data  [DEPTH];
    t_probe           w_probe [DEPTH];

    // Cell chain with neighbor links for shifting and the probe path.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic             w_lv;
        logic [VAL_W-1:0] w_ld;
        logic             w_rv;
        logic [VAL_W-1:0] w_rd;
        t_probe           w_pin;

        if (gi == 0) begin : g_head
            assign w_lv  = 1'b1;
            assign w_ld  = '0;
            assign w_pin = w_launch;
        end else begin : g_mid
            assign w_lv  = w_valid[gi-1];
            assign w_ld  = w_data[gi-1];
            assign w_pin = w_probe[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rv = 1'b0;
            assign w_rd = '0;
        end else begin : g_body
            assign w_rv = w_valid[gi+1];
            assign w_rd = w_data[gi+1];
        end

        bale_cell #(
            .INDEX (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_left_valid  (w_lv),
            .i_left_data   (w_ld),
            .i_right_valid (w_rv),
            .i_right_data  (w_rd),
            .o_valid       (w_valid[gi]),
            .o_data        (w_data[gi]),
            .i_probe       (w_pin),
            .o_probe       (w_probe[gi])
        );
    end

    // Handshake and request checks.
    assign w_can_load  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == ST_IDLE) && w_can_load;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_pos       = CMP_W'(i_req.payload.position);
    assign w_cnt       = CMP_W'(r_count);

    // Response built from the probe that left the end of the chain.
    always_comb begin
        w_done             = '0;
        w_done.status      = !w_probe[DEPTH-1].hit;
        w_done.entry_count = CNT_W'(r_count);
        if (w_probe[DEPTH-1].hit) begin
            if (w_probe[DEPTH-1].search) begin
                w_done.found_index = w_probe[DEPTH-1].found_index;
            end else begin
                w_done.read_value = w_probe[DEPTH-1].data;
            end
        end
    end

    // Sequencer: decode, store update, probe launch and output loading.
    // While a probe walks the chain, the cells see the position captured at
    // acceptance rather than the live request payload.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_pos          = r_pos;
        n_out_valid    = r_out_valid && !o_rsp.ready;
        n_out          = r_out;
        n_hold         = r_hold;
        w_cmd.op       = CELL_HOLD;
        w_cmd.position = (r_state == ST_IDLE) ? i_req.payload.position : r_pos;
        w_cmd.value    = i_req.payload.item_value;
        w_launch       = '0;
        w_launch.data  = i_req.payload.item_value;
        w_res          = '0;
        w_res.status   = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_pos       = i_req.payload.position;
                    case (i_req.payload.mode)
                        MODE_APPEND: begin
                            if (!w_full) begin
                                w_cmd.op     = CELL_APPEND;
                                n_count      = r_count + 1'b1;
                                w_res.status = 1'b0;
                            end
                        end
                        MODE_INSERT: begin
                            if (!w_full && (w_pos <= w_cnt)) begin
                                w_cmd.op     = CELL_INSERT;
                                n_count      = r_count + 1'b1;
                                w_res.status = 1'b0;
                            end
                        end
                        MODE_REMOVE: begin
                            if (w_pos < w_cnt) begin
                                w_cmd.op     = CELL_REMOVE;
                                n_count      = r_count - 1'b1;
                                w_res.status = 1'b0;
                            end
                        end
                        MODE_SEARCH: begin
                            w_launch.active = 1'b1;
                            w_launch.search = 1'b1;
                            n_out_valid     = r_out_valid && !o_rsp.ready;
                            n_state         = ST_WALK;
                        end
                        MODE_READ: begin
                            if (w_pos < w_cnt) begin
                                w_launch.active = 1'b1;
                                w_launch.data   = '0;
                                n_out_valid     = r_out_valid && !o_rsp.ready;
                                n_state         = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                    w_res.entry_count = CNT_W'(n_count);
                    if (n_state == ST_IDLE) begin
                        n_out = w_res;
                    end
                end
            end
            ST_WALK: begin
                if (w_probe[DEPTH-1].active) begin
                    if (w_can_load) begin
                        n_out_valid = 1'b1;
                        n_out       = w_done;
                        n_state     = ST_IDLE;
                    end else begin
                        n_hold  = w_done;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_out       = r_hold;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload registers.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule
